// ===== sv/btxq_pkg.sv =====
// Shared types and codes for the bit trie XOR query engine.
// Used by btxq_ctrl, btxq_datapath and bit_trie_xor_query_engine; no dependencies.
package btxq_pkg;

  localparam int VAL_W = 31;
  localparam int STATUS_W = 2;
  localparam int CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_MAXQ   = 3'd2,
    CMD_MINQ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } btxq_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } btxq_st_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } btxq_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]    xor_result;
    logic [STATUS_W-1:0] status;
  } btxq_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_READ_PREF,
    OP_READ_ALT,
    OP_STEP,
    OP_NEED,
    OP_ROOT_UPD,
    OP_UPD_WRITE,
    OP_LINK,
    OP_ALLOC,
    OP_FINISH
  } btxq_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_Q_LEVEL,
    S_Q_EVAL,
    S_Q_ALT,
    S_A_LEVEL,
    S_A_STEP,
    S_A_CHK,
    S_R_LEVEL,
    S_R_EVAL,
    S_U_START,
    S_U_LEVEL,
    S_U_WRITE,
    S_U_ALLOC,
    S_DONE
  } btxq_state_t;

  typedef struct packed {
    btxq_op_t op;
    btxq_st_t status;
  } btxq_ctl_t;

  typedef struct packed {
    btxq_cmd_t cmd;
    logic      pref_nz;
    logic      alt_nz;
    logic      rd_cnt_nz;
    logic      root_empty;
    logic      root_full;
    logic      lvl_last;
    logic      pool_ok;
    logic      out_free;
  } btxq_stat_t;

endpackage

// ===== sv/btxq_ctrl.sv =====
// Controller state machine of the bit trie XOR query engine.
// Depends on btxq_pkg; drives btxq_datapath through command and status structs.
module btxq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  btxq_pkg::btxq_stat_t stat,
  output btxq_pkg::btxq_ctl_t  ctl
);

  btxq_pkg::btxq_state_t state, state_next;
  btxq_pkg::btxq_st_t    st_code, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= btxq_pkg::S_IDLE;
      st_code <= btxq_pkg::ST_OK;
    end else begin
      state   <= state_next;
      st_code <= st_next;
    end
  end

  assign req_stall = (state != btxq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    st_next    = st_code;
    case (state)
      btxq_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = btxq_pkg::S_DISPATCH;
          st_next    = btxq_pkg::ST_OK;
        end
      end
      btxq_pkg::S_DISPATCH: begin
        case (stat.cmd)
          btxq_pkg::CMD_ADD: begin
            if (stat.root_full) begin
              state_next = btxq_pkg::S_DONE;
              st_next    = btxq_pkg::ST_FULL;
            end else begin
              state_next = btxq_pkg::S_A_LEVEL;
            end
          end
          btxq_pkg::CMD_REMOVE: begin
            if (stat.root_empty) begin
              state_next = btxq_pkg::S_DONE;
              st_next    = btxq_pkg::ST_ABSENT;
            end else begin
              state_next = btxq_pkg::S_R_LEVEL;
            end
          end
          btxq_pkg::CMD_MAXQ, btxq_pkg::CMD_MINQ: begin
            if (stat.root_empty) begin
              state_next = btxq_pkg::S_DONE;
              st_next    = btxq_pkg::ST_EMPTY;
            end else begin
              state_next = btxq_pkg::S_Q_LEVEL;
            end
          end
          default: state_next = btxq_pkg::S_DONE;
        endcase
      end
      btxq_pkg::S_Q_LEVEL: begin
        if (stat.pref_nz) begin
          state_next = btxq_pkg::S_Q_EVAL;
        end else if (stat.alt_nz) begin
          state_next = btxq_pkg::S_Q_ALT;
        end else begin
          state_next = btxq_pkg::S_DONE;
        end
      end
      btxq_pkg::S_Q_EVAL: begin
        if (stat.rd_cnt_nz) begin
          state_next = stat.lvl_last ? btxq_pkg::S_DONE : btxq_pkg::S_Q_LEVEL;
        end else if (stat.alt_nz) begin
          state_next = btxq_pkg::S_Q_ALT;
        end else begin
          state_next = btxq_pkg::S_DONE;
        end
      end
      btxq_pkg::S_Q_ALT: begin
        state_next = stat.lvl_last ? btxq_pkg::S_DONE : btxq_pkg::S_Q_LEVEL;
      end
      btxq_pkg::S_A_LEVEL: begin
        state_next = stat.pref_nz ? btxq_pkg::S_A_STEP : btxq_pkg::S_A_CHK;
      end
      btxq_pkg::S_A_STEP: begin
        state_next = stat.lvl_last ? btxq_pkg::S_A_CHK : btxq_pkg::S_A_LEVEL;
      end
      btxq_pkg::S_A_CHK: begin
        if (stat.pool_ok) begin
          state_next = btxq_pkg::S_U_START;
        end else begin
          state_next = btxq_pkg::S_DONE;
          st_next    = btxq_pkg::ST_FULL;
        end
      end
      btxq_pkg::S_R_LEVEL: begin
        if (stat.pref_nz) begin
          state_next = btxq_pkg::S_R_EVAL;
        end else begin
          state_next = btxq_pkg::S_DONE;
          st_next    = btxq_pkg::ST_ABSENT;
        end
      end
      btxq_pkg::S_R_EVAL: begin
        if (stat.rd_cnt_nz) begin
          state_next = stat.lvl_last ? btxq_pkg::S_U_START : btxq_pkg::S_R_LEVEL;
        end else begin
          state_next = btxq_pkg::S_DONE;
          st_next    = btxq_pkg::ST_ABSENT;
        end
      end
      btxq_pkg::S_U_START: state_next = btxq_pkg::S_U_LEVEL;
      btxq_pkg::S_U_LEVEL: begin
        state_next = stat.pref_nz ? btxq_pkg::S_U_WRITE : btxq_pkg::S_U_ALLOC;
      end
      btxq_pkg::S_U_WRITE, btxq_pkg::S_U_ALLOC: begin
        state_next = stat.lvl_last ? btxq_pkg::S_DONE : btxq_pkg::S_U_LEVEL;
      end
      btxq_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = btxq_pkg::S_IDLE;
        end
      end
      default: state_next = btxq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op     = btxq_pkg::OP_NONE;
    ctl.status = st_code;
    case (state)
      btxq_pkg::S_IDLE: begin
        if (req_valid) begin
          ctl.op = btxq_pkg::OP_LOAD;
        end
      end
      btxq_pkg::S_DISPATCH: begin
        if (stat.cmd == btxq_pkg::CMD_CLEAR) begin
          ctl.op = btxq_pkg::OP_CLEAR;
        end
      end
      btxq_pkg::S_Q_LEVEL: begin
        if (stat.pref_nz) begin
          ctl.op = btxq_pkg::OP_READ_PREF;
        end else if (stat.alt_nz) begin
          ctl.op = btxq_pkg::OP_READ_ALT;
        end
      end
      btxq_pkg::S_Q_EVAL: begin
        if (stat.rd_cnt_nz) begin
          ctl.op = btxq_pkg::OP_STEP;
        end else if (stat.alt_nz) begin
          ctl.op = btxq_pkg::OP_READ_ALT;
        end
      end
      btxq_pkg::S_Q_ALT, btxq_pkg::S_A_STEP: ctl.op = btxq_pkg::OP_STEP;
      btxq_pkg::S_A_LEVEL: begin
        ctl.op = stat.pref_nz ? btxq_pkg::OP_READ_PREF : btxq_pkg::OP_NEED;
      end
      btxq_pkg::S_R_LEVEL: begin
        if (stat.pref_nz) begin
          ctl.op = btxq_pkg::OP_READ_PREF;
        end
      end
      btxq_pkg::S_R_EVAL: begin
        if (stat.rd_cnt_nz) begin
          ctl.op = btxq_pkg::OP_STEP;
        end
      end
      btxq_pkg::S_U_START: ctl.op = btxq_pkg::OP_ROOT_UPD;
      btxq_pkg::S_U_LEVEL: begin
        ctl.op = stat.pref_nz ? btxq_pkg::OP_READ_PREF : btxq_pkg::OP_LINK;
      end
      btxq_pkg::S_U_WRITE: ctl.op = btxq_pkg::OP_UPD_WRITE;
      btxq_pkg::S_U_ALLOC: ctl.op = btxq_pkg::OP_ALLOC;
      btxq_pkg::S_DONE: begin
        if (stat.out_free) begin
          ctl.op = btxq_pkg::OP_FINISH;
        end
      end
      default: ctl.op = btxq_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== sv/btxq_datapath.sv =====
// Datapath of the bit trie XOR query engine: node memory, root node, walk registers.
// Depends on btxq_pkg; steered by btxq_ctrl.
module btxq_datapath #(
  parameter int VALUE_BITS    = 31,
  parameter int NODE_CAPACITY = 65536,
  parameter int COUNT_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  btxq_pkg::btxq_ctl_t  ctl,
  output btxq_pkg::btxq_stat_t stat,
  input  btxq_pkg::btxq_req_t  req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output btxq_pkg::btxq_res_t  res
);

  localparam int PTR_W  = $clog2(NODE_CAPACITY);
  localparam int LVL_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int NEED_W = $clog2(VALUE_BITS + 1);
  localparam int SUM_W  = PTR_W + NEED_W + 1;
  localparam int ENT_W  = 2 * PTR_W + COUNT_BITS;
  localparam logic [LVL_W-1:0]      LVL_TOP = LVL_W'(VALUE_BITS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  function automatic logic [ENT_W-1:0] pack_ent(input logic [PTR_W-1:0] z,
                                                input logic [PTR_W-1:0] o,
                                                input logic [COUNT_BITS-1:0] c);
    return {o, z, c};
  endfunction

  logic [ENT_W-1:0] mem [NODE_CAPACITY];
  logic [ENT_W-1:0] rd_data;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [PTR_W-1:0] mem_raddr;

  logic [btxq_pkg::CMD_W-1:0] req_cmd;
  logic [VALUE_BITS-1:0]      req_val;
  logic [LVL_W-1:0]           lvl;
  logic [NEED_W-1:0]          need;
  logic [VALUE_BITS-1:0]      acc;
  logic                       took_alt;
  logic [PTR_W-1:0]           rd_idx;
  logic [PTR_W-1:0]           cur_idx;
  logic [PTR_W-1:0]           cur_zero;
  logic [PTR_W-1:0]           cur_one;
  logic [COUNT_BITS-1:0]      cur_cnt;
  logic [PTR_W-1:0]           root_zero;
  logic [PTR_W-1:0]           root_one;
  logic [COUNT_BITS-1:0]      root_cnt;
  logic [PTR_W:0]             next_free;

  logic                  is_add;
  logic                  is_query;
  logic                  vb;
  logic                  pb;
  logic [PTR_W-1:0]      child_pref;
  logic [PTR_W-1:0]      child_alt;
  logic [PTR_W-1:0]      rd_zero;
  logic [PTR_W-1:0]      rd_one;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] rd_cnt_upd;
  logic [COUNT_BITS-1:0] root_cnt_upd;
  logic [PTR_W-1:0]      nf_ptr;
  logic [ENT_W-1:0]      link_ent;

  assign is_add     = (req_cmd == btxq_pkg::CMD_ADD);
  assign is_query   = (req_cmd == btxq_pkg::CMD_MAXQ) || (req_cmd == btxq_pkg::CMD_MINQ);
  assign vb         = req_val[lvl];
  assign pb         = vb ^ (req_cmd == btxq_pkg::CMD_MAXQ);
  assign child_pref = pb ? cur_one : cur_zero;
  assign child_alt  = pb ? cur_zero : cur_one;

  assign rd_cnt  = rd_data[COUNT_BITS-1:0];
  assign rd_zero = rd_data[COUNT_BITS +: PTR_W];
  assign rd_one  = rd_data[COUNT_BITS+PTR_W +: PTR_W];

  assign rd_cnt_upd   = is_add ? rd_cnt + CNT_ONE : rd_cnt - CNT_ONE;
  assign root_cnt_upd = is_add ? root_cnt + CNT_ONE : root_cnt - CNT_ONE;
  assign nf_ptr       = next_free[PTR_W-1:0];
  assign link_ent     = pb ? pack_ent(cur_zero, nf_ptr, cur_cnt)
                           : pack_ent(nf_ptr, cur_one, cur_cnt);

  always_comb begin
    stat.cmd        = btxq_pkg::btxq_cmd_t'(req_cmd);
    stat.pref_nz    = (child_pref != '0);
    stat.alt_nz     = (child_alt != '0);
    stat.rd_cnt_nz  = (rd_cnt != '0);
    stat.root_empty = (root_cnt == '0);
    stat.root_full  = &root_cnt;
    stat.lvl_last   = (lvl == '0);
    stat.pool_ok    = (SUM_W'(next_free) + SUM_W'(need)) <= SUM_W'(NODE_CAPACITY);
    stat.out_free   = !res_valid || !res_stall;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = pack_ent(rd_zero, rd_one, rd_cnt_upd);
    mem_raddr = child_pref;
    case (ctl.op)
      btxq_pkg::OP_READ_ALT: mem_raddr = child_alt;
      btxq_pkg::OP_UPD_WRITE: mem_we = 1'b1;
      btxq_pkg::OP_LINK: begin
        mem_we    = (cur_idx != '0);
        mem_waddr = cur_idx;
        mem_wdata = link_ent;
      end
      btxq_pkg::OP_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = nf_ptr;
        mem_wdata = pack_ent('0, '0, CNT_ONE);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      btxq_pkg::OP_LOAD: begin
        req_cmd  <= req.cmd;
        req_val  <= VALUE_BITS'(req.value);
        lvl      <= LVL_TOP;
        need     <= '0;
        acc      <= '0;
        cur_idx  <= '0;
        cur_zero <= root_zero;
        cur_one  <= root_one;
        cur_cnt  <= root_cnt;
      end
      btxq_pkg::OP_READ_PREF: begin
        rd_idx   <= child_pref;
        took_alt <= 1'b0;
      end
      btxq_pkg::OP_READ_ALT: begin
        rd_idx   <= child_alt;
        took_alt <= 1'b1;
      end
      btxq_pkg::OP_STEP: begin
        if (is_query) begin
          acc[lvl] <= pb ^ vb ^ took_alt;
        end
        cur_idx  <= rd_idx;
        cur_zero <= rd_zero;
        cur_one  <= rd_one;
        cur_cnt  <= rd_cnt;
        lvl      <= lvl - LVL_W'(1);
      end
      btxq_pkg::OP_NEED: need <= NEED_W'(lvl) + NEED_W'(1);
      btxq_pkg::OP_ROOT_UPD: begin
        lvl      <= LVL_TOP;
        cur_idx  <= '0;
        cur_zero <= root_zero;
        cur_one  <= root_one;
        cur_cnt  <= root_cnt_upd;
      end
      btxq_pkg::OP_UPD_WRITE: begin
        cur_idx  <= rd_idx;
        cur_zero <= rd_zero;
        cur_one  <= rd_one;
        cur_cnt  <= rd_cnt_upd;
        lvl      <= lvl - LVL_W'(1);
      end
      btxq_pkg::OP_ALLOC: begin
        cur_idx  <= nf_ptr;
        cur_zero <= '0;
        cur_one  <= '0;
        cur_cnt  <= CNT_ONE;
        lvl      <= lvl - LVL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_zero <= '0;
      root_one  <= '0;
      root_cnt  <= '0;
      next_free <= (PTR_W + 1)'(1);
    end else begin
      case (ctl.op)
        btxq_pkg::OP_CLEAR: begin
          root_zero <= '0;
          root_one  <= '0;
          root_cnt  <= '0;
          next_free <= (PTR_W + 1)'(1);
        end
        btxq_pkg::OP_ROOT_UPD: root_cnt <= root_cnt_upd;
        btxq_pkg::OP_LINK: begin
          if (cur_idx == '0) begin
            if (pb) begin
              root_one <= nf_ptr;
            end else begin
              root_zero <= nf_ptr;
            end
          end
        end
        btxq_pkg::OP_ALLOC: next_free <= next_free + (PTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.op == btxq_pkg::OP_FINISH) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == btxq_pkg::OP_FINISH) begin
      res.status <= ctl.status;
      if (is_query && (ctl.status == btxq_pkg::ST_OK)) begin
        res.xor_result <= btxq_pkg::VAL_W'(acc);
      end else begin
        res.xor_result <= '0;
      end
    end
  end

endmodule

// ===== sv/bit_trie_xor_query_engine.sv =====
// Top level of the bit trie XOR query engine: controller plus datapath.
// Depends on btxq_pkg, btxq_ctrl and btxq_datapath.
//
//   Channel   Direction  Handshake            Payload
//   request   in         req_valid/req_stall  req: cmd, value
//   result    out        res_valid/res_stall  res: xor_result, status
//
// A query walks the trie from the top level down, reading the preferred child at each level
// and taking the other child where the preferred one is absent or has a zero count.
// Add and remove run a check walk and then an update walk.
// Clear and unused command codes go from dispatch straight to done; every request ends in idle.
// Reset empties the root node at once; other nodes are written when allocated.
// A finished result waits in the output register while the next request is taken.
module bit_trie_xor_query_engine #(
  parameter int VALUE_BITS    = 31,
  parameter int NODE_CAPACITY = 65536,
  parameter int COUNT_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  btxq_pkg::btxq_req_t req,
  output logic                res_valid,
  input  logic                res_stall,
  output btxq_pkg::btxq_res_t res
);

  btxq_pkg::btxq_ctl_t  ctl;
  btxq_pkg::btxq_stat_t stat;

  btxq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  btxq_datapath #(
    .VALUE_BITS    (VALUE_BITS),
    .NODE_CAPACITY (NODE_CAPACITY),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
